@@ hw/rtl/spit_pkg.sv @@
// Shared types and constants for the segment pair intersection test.
// Used by spit_term, spit_sum and segment_pair_intersect_test_core.
package spit_pkg;

   // Coordinate format: signed, with FRAC_BITS fractional bits.
   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int TOL_BITS   = 31;

   // Operand of a determinant term: a coordinate or a coordinate difference.
   localparam int OP_W   = COORD_BITS + 1;
   // Product of two operands, and the low/high split used for the third factor.
   localparam int PROD_W = 2 * OP_W;
   localparam int SPLIT  = OP_W;
   // Exact determinant: six triple products of OP_W-bit values.
   localparam int DET_W  = 3 * OP_W + 1;
   localparam int SCALE  = 2 * FRAC_BITS;
   localparam int SHIFT_W = DET_W - SCALE;

   localparam int TERMS = 6;
   localparam int DETS  = 5;

   // Result codes.
   localparam logic [1:0] VERDICT_MISS  = 2'd0;
   localparam logic [1:0] VERDICT_HIT   = 2'd1;
   localparam logic [1:0] VERDICT_DEGEN = 2'd2;

   // Register map.
   localparam int         ADDR_W        = 3;
   localparam logic [ADDR_W-1:0] ADDR_TOLERANCE = 3'd0;
   localparam logic [TOL_BITS-1:0] TOLERANCE_RESET = 31'd66;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [OP_W-1:0]       op_type;
   typedef logic signed [DET_W-1:0]      det_type;

   typedef struct packed {
      coord_type p1_x;
      coord_type p1_y;
      coord_type p1_z;
      coord_type p2_x;
      coord_type p2_y;
      coord_type p2_z;
      coord_type q1_x;
      coord_type q1_y;
      coord_type q1_z;
      coord_type q2_x;
      coord_type q2_y;
      coord_type q2_z;
   } seg_pair_type;

   typedef struct packed {
      logic [1:0] verdict;
      logic       coplanar;
   } result_type;

   typedef struct packed {
      op_type x;
      op_type y;
      op_type z;
   } vec_type;

   // Stage enables for the multiply stages and for the sum stages.
   typedef struct packed {
      logic b;
      logic c;
      logic d;
   } term_en_type;

   typedef struct packed {
      logic e;
      logic f;
   } sum_en_type;

endpackage

@@ hw/rtl/spit_term.sv @@
// One exact triple product x*y*z, cut into three register stages.
// Depends on spit_pkg.
module spit_term (
   input  logic                 clock,
   input  spit_pkg::term_en_type en,
   input  spit_pkg::op_type     x,
   input  spit_pkg::op_type     y,
   input  spit_pkg::op_type     z,
   output spit_pkg::det_type    term
);
   import spit_pkg::*;

   logic signed [PROD_W-1:0]   m_ff, m_in;
   op_type                     z_ff;
   logic signed [OP_W-1:0]     hi;
   logic signed [OP_W:0]       lo;
   logic signed [PROD_W-1:0]   ph_ff, ph_in;
   logic signed [PROD_W:0]     pl_ff, pl_in;
   det_type                    term_ff, term_in;

   // First stage: product of the first two factors.
   assign m_in = x * y;

   // Second stage: the 66-bit product times the third factor, in two halves.
   assign hi    = m_ff[PROD_W-1:SPLIT];
   assign lo    = {1'b0, m_ff[SPLIT-1:0]};
   assign ph_in = hi * z_ff;
   assign pl_in = lo * z_ff;

   // Third stage: recombine the halves.
   assign term_in = (DET_W'(ph_ff) <<< SPLIT) + DET_W'(pl_ff);

   always_ff @(posedge clock) begin
      if (en.b) begin
         m_ff <= m_in;
         z_ff <= z;
      end
      if (en.c) begin
         ph_ff <= ph_in;
         pl_ff <= pl_in;
      end
      if (en.d) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule

@@ hw/rtl/spit_sum.sv @@
// Sums six triple products into one exact determinant over two stages.
// Depends on spit_pkg; terms 0..2 are added and terms 3..5 subtracted.
module spit_sum (
   input  logic                clock,
   input  spit_pkg::sum_en_type en,
   input  spit_pkg::det_type   term [spit_pkg::TERMS],
   output spit_pkg::det_type   det
);
   import spit_pkg::*;

   det_type s0_ff, s1_ff, s2_ff;
   det_type s0_in, s1_in, s2_in;
   det_type det_ff, det_in;

   // Pair each positive term with a negative one.
   assign s0_in = term[0] - term[3];
   assign s1_in = term[1] - term[4];
   assign s2_in = term[2] - term[5];

   assign det_in = s0_ff + s1_ff + s2_ff;

   always_ff @(posedge clock) begin
      if (en.e) begin
         s0_ff <= s0_in;
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
      if (en.f) begin
         det_ff <= det_in;
      end
   end

   assign det = det_ff;

endmodule

@@ hw/rtl/segment_pair_intersect_test_core.sv @@
// Top level of the 3D segment pair intersection test.
// Depends on spit_pkg, spit_term and spit_sum.
//
// The core takes one segment pair per cycle while req_stall is low and
// returns one result per item, in input order. The path is a seven-stage
// pipeline: differences and box tests, two multiply stages and a recombine
// stage per triple product (thirty in parallel), two stages that sum each
// determinant, and a final stage that scales, saturates and decides the
// verdict. Each stage holds its item while the next one cannot take it, so
// a stalled result does not block items that fill the empty stages behind
// it. The tolerance register must only be written while no item is in flight.
module segment_pair_intersect_test_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  spit_pkg::seg_pair_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output spit_pkg::result_type          rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [spit_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import spit_pkg::*;

   localparam int STAGES = 7;
   localparam int LAST   = STAGES - 1;

   typedef struct packed {
      logic       degen;
      logic [3:0] box;
   } flag_type;

   logic [TOL_BITS-1:0] tol_ff, tol_in;
   logic [STAGES-1:0]   valid_ff, valid_in;
   logic [STAGES-1:0]   en;
   vec_type             va_ff [DETS];
   vec_type             vb_ff [DETS];
   vec_type             vc_ff [DETS];
   vec_type             va_in [DETS];
   vec_type             vb_in [DETS];
   vec_type             vc_in [DETS];
   flag_type            flag_ff [LAST];
   flag_type            flag_in;
   det_type             term [DETS][TERMS];
   det_type             det [DETS];
   logic [DETS-1:0]     nz, neg, zer;
   result_type          rsp_ff, rsp_in;
   vec_type             p1, p2, q1, q2;
   term_en_type         term_en;
   sum_en_type          sum_en;

   function automatic logic coord_near_zero(op_type d, logic [TOL_BITS-1:0] tol);
      logic signed [OP_W:0] dv;
      logic signed [OP_W:0] tv;
      dv = {d[OP_W-1], d};
      tv = {3'b000, tol};
      return (dv < tv) && (dv > -tv);
   endfunction

   function automatic logic in_span(coord_type d, coord_type e0, coord_type e1);
      return ((d >= e0) && (d <= e1)) || ((d >= e1) && (d <= e0));
   endfunction

   // Scale by 2*FRAC_BITS (floor), saturate to a coordinate, test the band.
   function automatic logic det_near_zero(det_type det_v, logic [TOL_BITS-1:0] tol);
      logic signed [SHIFT_W-1:0]    sh;
      logic                         fits;
      coord_type                    v;
      logic signed [COORD_BITS:0]   vv;
      logic signed [COORD_BITS:0]   tv;
      sh   = det_v[DET_W-1:SCALE];
      fits = (sh[SHIFT_W-1:COORD_BITS-1] == {(SHIFT_W-COORD_BITS+1){sh[SHIFT_W-1]}});
      if (fits) begin
         v = sh[COORD_BITS-1:0];
      end else if (sh[SHIFT_W-1]) begin
         v = {1'b1, {(COORD_BITS-1){1'b0}}};
      end else begin
         v = {1'b0, {(COORD_BITS-1){1'b1}}};
      end
      vv = {v[COORD_BITS-1], v};
      tv = {2'b00, tol};
      return (vv < tv) && (vv > -tv);
   endfunction

   // Configuration register.
   assign pready = 1'b1;
   always_comb begin
      tol_in = tol_ff;
      if (psel && penable && pwrite && (paddr == ADDR_TOLERANCE)) begin
         tol_in = pwdata[TOL_BITS-1:0];
      end
   end
   assign prdata = (paddr == ADDR_TOLERANCE) ? {1'b0, tol_ff} : 32'd0;

   // Each stage takes a new item when it is empty or when its item moves on.
   always_comb begin
      en[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end
   assign req_stall = !en[0];

   always_comb begin
      valid_in = valid_ff;
      if (en[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (en[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= TOLERANCE_RESET;
         valid_ff <= '0;
      end else begin
         tol_ff   <= tol_in;
         valid_ff <= valid_in;
      end
   end

   // Stage zero: widen the points, form differences, test ends and boxes.
   always_comb begin
      p1 = '{OP_W'(req_data.p1_x), OP_W'(req_data.p1_y), OP_W'(req_data.p1_z)};
      p2 = '{OP_W'(req_data.p2_x), OP_W'(req_data.p2_y), OP_W'(req_data.p2_z)};
      q1 = '{OP_W'(req_data.q1_x), OP_W'(req_data.q1_y), OP_W'(req_data.q1_z)};
      q2 = '{OP_W'(req_data.q2_x), OP_W'(req_data.q2_y), OP_W'(req_data.q2_z)};

      // Triple product of p2-p1, q2-q1 and q1-p1.
      va_in[0] = '{p2.x - p1.x, p2.y - p1.y, p2.z - p1.z};
      vb_in[0] = '{q2.x - q1.x, q2.y - q1.y, q2.z - q1.z};
      vc_in[0] = '{q1.x - p1.x, q1.y - p1.y, q1.z - p1.z};
      // Origin-based determinants of each endpoint against the other segment.
      va_in[1] = p1; vb_in[1] = p2; vc_in[1] = q1;
      va_in[2] = p1; vb_in[2] = p2; vc_in[2] = q2;
      va_in[3] = q1; vb_in[3] = q2; vc_in[3] = p1;
      va_in[4] = q1; vb_in[4] = q2; vc_in[4] = p2;

      flag_in.degen =
         (coord_near_zero(p1.x - p2.x, tol_ff) && coord_near_zero(p1.y - p2.y, tol_ff)
          && coord_near_zero(p1.z - p2.z, tol_ff)) ||
         (coord_near_zero(q1.x - q2.x, tol_ff) && coord_near_zero(q1.y - q2.y, tol_ff)
          && coord_near_zero(q1.z - q2.z, tol_ff));
      flag_in.box[0] = in_span(req_data.q1_x, req_data.p1_x, req_data.p2_x) &&
                       in_span(req_data.q1_y, req_data.p1_y, req_data.p2_y) &&
                       in_span(req_data.q1_z, req_data.p1_z, req_data.p2_z);
      flag_in.box[1] = in_span(req_data.q2_x, req_data.p1_x, req_data.p2_x) &&
                       in_span(req_data.q2_y, req_data.p1_y, req_data.p2_y) &&
                       in_span(req_data.q2_z, req_data.p1_z, req_data.p2_z);
      flag_in.box[2] = in_span(req_data.p1_x, req_data.q1_x, req_data.q2_x) &&
                       in_span(req_data.p1_y, req_data.q1_y, req_data.q2_y) &&
                       in_span(req_data.p1_z, req_data.q1_z, req_data.q2_z);
      flag_in.box[3] = in_span(req_data.p2_x, req_data.q1_x, req_data.q2_x) &&
                       in_span(req_data.p2_y, req_data.q1_y, req_data.q2_y) &&
                       in_span(req_data.p2_z, req_data.q1_z, req_data.q2_z);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int d = 0; d < DETS; d++) begin
            va_ff[d] <= va_in[d];
            vb_ff[d] <= vb_in[d];
            vc_ff[d] <= vc_in[d];
         end
         flag_ff[0] <= flag_in;
      end
      for (int k = 1; k < LAST; k++) begin
         if (en[k]) begin
            flag_ff[k] <= flag_ff[k-1];
         end
      end
   end

   // Multiply and sum stages, one group of six terms per determinant.
   assign term_en = '{b: en[1], c: en[2], d: en[3]};
   assign sum_en  = '{e: en[4], f: en[5]};

   for (genvar d = 0; d < DETS; d++) begin : g_det
      spit_term u_t0 (.clock(clock), .en(term_en), .x(va_ff[d].x), .y(vb_ff[d].y),
                      .z(vc_ff[d].z), .term(term[d][0]));
      spit_term u_t1 (.clock(clock), .en(term_en), .x(vb_ff[d].x), .y(vc_ff[d].y),
                      .z(va_ff[d].z), .term(term[d][1]));
      spit_term u_t2 (.clock(clock), .en(term_en), .x(vc_ff[d].x), .y(va_ff[d].y),
                      .z(vb_ff[d].z), .term(term[d][2]));
      spit_term u_t3 (.clock(clock), .en(term_en), .x(va_ff[d].x), .y(vb_ff[d].z),
                      .z(vc_ff[d].y), .term(term[d][3]));
      spit_term u_t4 (.clock(clock), .en(term_en), .x(vc_ff[d].x), .y(vb_ff[d].y),
                      .z(va_ff[d].z), .term(term[d][4]));
      spit_term u_t5 (.clock(clock), .en(term_en), .x(vb_ff[d].x), .y(va_ff[d].y),
                      .z(vc_ff[d].z), .term(term[d][5]));
      spit_sum u_sum (.clock(clock), .en(sum_en), .term(term[d]), .det(det[d]));
   end

   // Final stage: band tests, signs and the verdict.
   always_comb begin
      for (int d = 0; d < DETS; d++) begin
         nz[d]  = det_near_zero(det[d], tol_ff);
         neg[d] = det[d][DET_W-1];
         zer[d] = (det[d] == '0);
      end
      rsp_in.verdict  = VERDICT_MISS;
      rsp_in.coplanar = 1'b0;
      if (flag_ff[LAST-1].degen) begin
         rsp_in.verdict = VERDICT_DEGEN;
      end else if (nz[0]) begin
         rsp_in.coplanar = 1'b1;
         if ((nz[1] && flag_ff[LAST-1].box[0]) || (nz[2] && flag_ff[LAST-1].box[1]) ||
             (nz[3] && flag_ff[LAST-1].box[2]) || (nz[4] && flag_ff[LAST-1].box[3])) begin
            rsp_in.verdict = VERDICT_HIT;
         end else if (!zer[1] && !zer[2] && (neg[1] != neg[2]) &&
                      !zer[3] && !zer[4] && (neg[3] != neg[4])) begin
            rsp_in.verdict = VERDICT_HIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[LAST]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff[LAST];
   assign rsp_data  = rsp_ff;

   // A degenerate pair never reports coplanar.
   a_degen_not_coplanar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.verdict == VERDICT_DEGEN) |-> !rsp_data.coplanar)
      else $error("degenerate result marked coplanar");

   // A hit needs the coplanarity test to have passed.
   a_hit_needs_coplanar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.verdict == VERDICT_HIT) |-> rsp_data.coplanar)
      else $error("hit without coplanar segments");

   // Only the three defined codes leave the core.
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.verdict == VERDICT_MISS) || (rsp_data.verdict == VERDICT_HIT)
                    || (rsp_data.verdict == VERDICT_DEGEN))
      else $error("undefined verdict code");

   // An empty pipeline never stalls the input.
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == '0) |-> !req_stall)
      else $error("stall with an empty pipeline");

endmodule
